// ===== hw/rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar kalman filter
// register indexes, field widths and the divider control and status structs
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned RegW    = 32;
  localparam int unsigned MeasW   = 16;
  localparam int unsigned GainW   = 16;

  localparam logic [CfgIdxW-1:0] RegProcessNoise     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 8'd1;

  localparam logic [GainW-1:0] GainMax = 16'hFFFF;

  typedef struct packed {
    logic            start;
    logic [RegW-1:0] p;
    logic [RegW-1:0] r;
  } skf_div_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [GainW-1:0] gain;
  } skf_div_st_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter.sv =====
// path: an input transfer steps through the predict, divider start, divide,
// estimate multiply and update, covariance multiply and update and output states
// to result valid; r zero skips the divide iterations. output stalls delay the next
// measurement, which waits for the last result to load; input ready only while idle
// one shared 18x34 multiplier serves the estimate update and the covariance update
// reset: estimate and covariance clear to zero, q clears to zero, r resets to 1.0
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional fixed-point kalman filter
// sequencer around an iterative divider and one shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [skf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [skf_pkg::RegW-1:0]     cfg_data_i,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire [skf_pkg::MeasW-1:0]    s_axis_tdata_i,   // [15:0] measurement
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  output logic [skf_pkg::RegW-1:0]    m_axis_tdata_o    // [31:0] estimate
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPred  = 4'd1;
  localparam logic [3:0] StStart = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StMul1  = 4'd4;
  localparam logic [3:0] StEst   = 4'd5;
  localparam logic [3:0] StMul2  = 4'd6;
  localparam logic [3:0] StCov   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]                      state_q, state_d;
  logic [skf_pkg::RegW-1:0]        q_noise_q, r_noise_q;
  logic signed [skf_pkg::RegW-1:0] est_q;
  logic [skf_pkg::RegW-1:0]        cov_q;
  logic [skf_pkg::RegW-1:0]        p_q;
  logic [skf_pkg::GainW-1:0]       gain_q;
  logic signed [skf_pkg::MeasW-1:0] meas_q;
  logic signed [51:0]              prod_q;
  logic                            out_valid_q;
  logic [skf_pkg::RegW-1:0]        out_data_q;

  logic                            in_xfer, out_xfer, out_load;
  logic [skf_pkg::RegW:0]          p_sum;
  logic signed [32:0]              diff;
  logic signed [17:0]              mul_a;
  logic signed [33:0]              mul_b;
  logic signed [51:0]              mul_p;
  logic signed [35:0]              corr, est_sum;
  logic signed [skf_pkg::RegW-1:0] est_sat;
  logic [16:0]                     one_minus_gain;

  skf_pkg::skf_div_ctl_t div_ctl;
  skf_pkg::skf_div_st_t  div_st;

  skf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .st_o   (div_st)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = out_valid_q && m_axis_tready_i;
  assign out_load        = (state_q == StOut) && (!out_valid_q || m_axis_tready_i);

  assign div_ctl.start = (state_q == StStart);
  assign div_ctl.p     = p_q;
  assign div_ctl.r     = r_noise_q;

  assign p_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign diff  = 33'(signed'({meas_q, 16'h0000})) - 33'(est_q);
  assign one_minus_gain = 17'h10000 - {1'b0, gain_q};

  // shared multiplier
  always_comb begin
    if (state_q == StMul1) begin
      mul_a = signed'({2'b00, gain_q});
      mul_b = 34'(diff);
    end else begin
      mul_a = signed'({1'b0, one_minus_gain});
      mul_b = signed'({2'b00, p_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  assign corr    = 36'(prod_q >>> 16);
  assign est_sum = 36'(est_q) + corr;
  always_comb begin
    if (est_sum > 36'sh0_7FFF_FFFF) begin
      est_sat = 32'sh7FFF_FFFF;
    end else if (est_sum < -36'sh0_8000_0000) begin
      est_sat = -32'sh8000_0000;
    end else begin
      est_sat = est_sum[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_xfer) state_d = StPred;
      StPred:  state_d = StStart;
      StStart: state_d = StDiv;
      StDiv:   if (div_st.done) state_d = StMul1;
      StMul1:  state_d = StEst;
      StEst:   state_d = StMul2;
      StMul2:  state_d = StCov;
      StCov:   state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      q_noise_q   <= '0;
      r_noise_q   <= 32'h0001_0000;
      est_q       <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          skf_pkg::RegProcessNoise:     q_noise_q <= cfg_data_i;
          skf_pkg::RegMeasurementNoise: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StEst) est_q <= est_sat;
      // product never exceeds p * 2^16
      if (state_q == StCov) cov_q <= prod_q[47:16];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) meas_q <= s_axis_tdata_i;
    if (state_q == StPred) p_q <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    if (div_st.done) gain_q <= div_st.gain;
    if (state_q == StMul1 || state_q == StMul2) prod_q <= mul_p;
    if (out_load) out_data_q <= est_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == StDiv)
    else $error("divider finished outside the divide state");

  a_cov_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCov |=> cov_q <= p_q)
    else $error("covariance grew past prediction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !out_load)
    else $error("result register overwritten while waiting");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div: iterative gain divider
// restoring division for nonzero r, one quotient bit per cycle: gain = floor(p * 2^16 / (p + r))
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire skf_pkg::skf_div_ctl_t ctl_i,
  output skf_pkg::skf_div_st_t       st_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [skf_pkg::RegW:0]     rem_q, rem_d;
  logic [skf_pkg::RegW:0]     den_q, den_d;
  logic [skf_pkg::GainW-1:0]  quo_q, quo_d;
  logic [skf_pkg::RegW+1:0]   shl;
  logic [skf_pkg::RegW+1:0]   shl_sub;
  logic                       ge;

  assign shl     = {rem_q, 1'b0};
  assign shl_sub = shl - {1'b0, den_q};
  assign ge      = shl >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (ctl_i.start) begin
      if (ctl_i.r == '0) begin
        // unity gain saturates, zero sum gives zero
        quo_d  = (ctl_i.p == '0) ? '0 : skf_pkg::GainMax;
        done_d = 1'b1;
      end else begin
        rem_d  = {1'b0, ctl_i.p};
        den_d  = {1'b0, ctl_i.p} + {1'b0, ctl_i.r};
        quo_d  = '0;
        cnt_d  = 5'd16;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // remainder stays below the divisor
      rem_d = ge ? shl_sub[skf_pkg::RegW:0]
                 : shl[skf_pkg::RegW:0];
      quo_d = {quo_q[skf_pkg::GainW-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d[skf_pkg::RegW:0];
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign st_o.gain = quo_q;

endmodule

`default_nettype wire

// ===== tb/sv/skf_estimate_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skf_estimate_checker: estimate predictor and result checker
// follows noise register writes and measurement transfers, computes the
// expected fixed-point kalman estimate for each one and compares it against
// every estimate transfer in order
// ----------------------------------------------------------------------------

module skf_estimate_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  input  wire                         cfg_ready_i,
  input  wire [skf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [skf_pkg::RegW-1:0]     cfg_data_i,
  input  wire                         s_axis_tvalid_i,
  input  wire                         s_axis_tready_i,
  input  wire [skf_pkg::MeasW-1:0]    s_axis_tdata_i,   // [15:0] measurement
  input  wire                         m_axis_tvalid_i,
  input  wire                         m_axis_tready_i,
  input  wire [skf_pkg::RegW-1:0]     m_axis_tdata_i,   // [31:0] estimate
  output int unsigned                 mismatches_o,
  output int unsigned                 outstanding_o
);

  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic signed [63:0] EstMax = 64'sd2147483647;
  localparam logic signed [63:0] EstMin = -64'sd2147483648;

  logic [31:0] process_noise;
  logic [31:0] measurement_noise;
  logic signed [31:0] estimate_state;
  logic [31:0] covariance_state;
  logic [31:0] estimates_due[$];
  logic [31:0] want;
  int unsigned fails = 0;

  // one filter step on the shadow state, returns the new estimate
  function automatic logic [31:0] kalman_update(input logic [15:0] meas);
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] gain;
    logic [63:0] cov;
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] est;
    p = {32'b0, covariance_state} + {32'b0, process_noise};
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + {32'b0, measurement_noise};
    if (den == 64'd0) begin
      gain = 64'd0;
    end else begin
      gain = (p << 16) / den;
      if (gain > 64'hFFFF) gain = 64'hFFFF;
    end
    diff = {{32{meas[15]}}, meas, 16'h0000} - {{32{estimate_state[31]}}, estimate_state};
    prod = $signed(gain) * diff;
    est = $signed({{32{estimate_state[31]}}, estimate_state}) + (prod >>> 16);
    if (est > EstMax) est = EstMax;
    if (est < EstMin) est = EstMin;
    estimate_state = est[31:0];
    cov = ((64'd65536 - gain) * p) >> 16;
    if (cov > 64'hFFFF_FFFF) cov = 64'hFFFF_FFFF;
    covariance_state = cov[31:0];
    return est[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_noise = '0;
      measurement_noise = OneQ16;
      estimate_state = '0;
      covariance_state = '0;
      estimates_due.delete();
      outstanding_o <= 0;
      mismatches_o <= fails;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == skf_pkg::RegProcessNoise) begin
          process_noise = cfg_data_i;
        end else if (cfg_index_i == skf_pkg::RegMeasurementNoise) begin
          measurement_noise = cfg_data_i;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        estimates_due.push_back(kalman_update(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (estimates_due.size() == 0) begin
          $display("%0t: unexpected estimate transfer, expected none, got %h",
                   $time, m_axis_tdata_i);
          fails++;
        end else begin
          want = estimates_due.pop_front();
          if (want !== m_axis_tdata_i) begin
            $display("%0t: estimate mismatch, expected %h, got %h",
                     $time, want, m_axis_tdata_i);
            fails++;
          end
        end
      end
      mismatches_o <= fails;
      outstanding_o <= estimates_due.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: scalar kalman filter stimulus and verdict
// directed noise settings and measurements at the corners, then random
// measurement streams under several idle and stall patterns with noise
// reprogrammed between segments; results are judged by the estimate checker
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned Segments     = 5;
  localparam int unsigned SegmentItems = 50;
  localparam logic [skf_pkg::CfgIdxW-1:0] RegUnmapped = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [skf_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [skf_pkg::RegW-1:0] cfg_data_i;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [skf_pkg::MeasW-1:0] s_axis_tdata_i;   // [15:0] measurement
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [skf_pkg::RegW-1:0] m_axis_tdata_o;    // [31:0] estimate

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  scalar_kalman_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  skf_estimate_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // leaves cfg_valid_i high, the caller lowers it after the last write
  task automatic cfg_write(input logic [skf_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_noise(input logic [31:0] q, input logic [31:0] r, input bit poke);
    logic [31:0] stray_idx;
    cfg_write(skf_pkg::RegProcessNoise, q);
    if (poke) begin
      stray_idx = $urandom_range(skf_pkg::RegMeasurementNoise + 1, RegUnmapped);
      cfg_write(stray_idx[skf_pkg::CfgIdxW-1:0], $urandom);
    end
    cfg_write(skf_pkg::RegMeasurementNoise, r);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_measurement(input logic [15:0] meas);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= meas;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // hold the sender until every estimate is back and the block is idle
  task automatic drain_estimates();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 32'h0004_0000);
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_measurement(input logic [15:0] prev);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2: return prev + 16'($signed($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] meas;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset noise values
    send_measurement(16'h7FFF);
    send_measurement(16'h8000);
    drain_estimates();
    // zero denominator, estimate held
    program_noise(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_measurement(16'h7FFF);
    send_measurement(16'h8000);
    drain_estimates();
    // unity gain saturation
    program_noise(32'h0001_0000, 32'h0000_0000, 1'b1);
    send_measurement(16'h7FFF);
    send_measurement(16'h8000);
    send_measurement(16'h0000);
    send_measurement(16'hFFFF);
    drain_estimates();
    // covariance overflow
    program_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_measurement(16'h8000);
    send_measurement(16'h7FFF);
    send_measurement(16'h0001);
    send_measurement(16'h5555);
    send_measurement(16'hAAAA);
    drain_estimates();
    program_noise(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_measurement(16'h7FFF);
    send_measurement(16'h8000);
    drain_estimates();
    program_noise(32'h0000_0100, 32'h0001_0000, 1'b1);
    send_measurement(16'h0000);
    send_measurement(16'h0001);
    send_measurement(16'hFFFF);
    send_measurement(16'h04D2);
    drain_estimates();

    meas = '0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int seg = 0; seg < Segments; seg++) begin
        program_noise(pick_noise(), pick_noise(), $urandom_range(0, 3) == 0);
        for (int k = 0; k < SegmentItems; k++) begin
          meas = pick_measurement(meas);
          send_measurement(meas);
        end
        drain_estimates();
      end
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/skf_pkg.sv
hw/rtl/skf_div.sv
hw/rtl/scalar_kalman_filter.sv
tb/sv/skf_estimate_checker.sv
tb/sv/testbench.sv
